// ----- design/mge_pkg.sv -----
// Shared types and constants for the monochrome glyph expander.
package mge_pkg;

  localparam int COORD_BITS_DEF = 11;
  localparam int PIXEL_BITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 2;
  localparam int CFG_IDX_BITS   = 3;

  typedef enum logic {
    OP_WINDOW = 1'b0,
    OP_PIXEL  = 1'b1
  } op_kind_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_GLYPH_W    = 3'd2,
    REG_GLYPH_H    = 3'd3,
    REG_ROW_STRIDE = 3'd4,
    REG_FG_COLOR   = 3'd5,
    REG_BG_COLOR   = 3'd6,
    REG_SKIP_BG    = 3'd7
  } cfg_reg_t;

endpackage

// ----- design/mono_glyph_expander.sv -----
// Top level of the monochrome glyph expander: registers, queue and both ends.
// The first result of a byte is registered in a queue entry and then in the output register.
// Throughput: one result per cycle at the output register while results are queued and
// out_stall is low; a queued byte yields 1 to 9 results (a row window on the first byte
// of a row plus one per drawn bit). Bytes with no results are not queued. A 2-entry queue decouples intake from output.
// Reset: registers take their defaults and the glyph restarts at the top row.
module mono_glyph_expander #(
  parameter int COORD_BITS = mge_pkg::COORD_BITS_DEF,
  parameter int PIXEL_BITS = mge_pkg::PIXEL_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [mge_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [((COORD_BITS > PIXEL_BITS) ? COORD_BITS : PIXEL_BITS)-1:0] cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            bitmap_byte,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  op_kind,
  output logic [COORD_BITS-1:0]                 win_left,
  output logic [COORD_BITS-1:0]                 win_right,
  output logic [COORD_BITS-1:0]                 win_row,
  output logic [PIXEL_BITS-1:0]                 pixel_word,
  output logic                                  last_of_item,
  output logic                                  glyph_done
);

  localparam int EW = 2 * COORD_BITS + 14;

  logic [COORD_BITS-1:0] origin_x, origin_y, glyph_width, glyph_height;
  logic [7:0]            row_stride;
  logic [PIXEL_BITS-1:0] fg_color, bg_color;
  logic                  skip_background;

  logic                  accept, q_push, q_pop, q_empty, q_full;
  logic [EW-1:0]         q_wdata, q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x        <= '0;
      origin_y        <= '0;
      glyph_width     <= COORD_BITS'(8);
      glyph_height    <= COORD_BITS'(8);
      row_stride      <= 8'd1;
      fg_color        <= '1;
      bg_color        <= '0;
      skip_background <= 1'b0;
    end else if (cfg_write) begin
      unique case (mge_pkg::cfg_reg_t'(cfg_index))
        mge_pkg::REG_ORIGIN_X:   origin_x        <= cfg_data[COORD_BITS-1:0];
        mge_pkg::REG_ORIGIN_Y:   origin_y        <= cfg_data[COORD_BITS-1:0];
        mge_pkg::REG_GLYPH_W:    glyph_width     <= cfg_data[COORD_BITS-1:0];
        mge_pkg::REG_GLYPH_H:    glyph_height    <= cfg_data[COORD_BITS-1:0];
        mge_pkg::REG_ROW_STRIDE: row_stride      <= cfg_data[7:0];
        mge_pkg::REG_FG_COLOR:   fg_color        <= cfg_data[PIXEL_BITS-1:0];
        mge_pkg::REG_BG_COLOR:   bg_color        <= cfg_data[PIXEL_BITS-1:0];
        mge_pkg::REG_SKIP_BG:    skip_background <= cfg_data[0];
      endcase
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  mge_front #(
    .COORD_BITS (COORD_BITS),
    .EW         (EW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .restart      (cfg_write),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .glyph_width  (glyph_width),
    .glyph_height (glyph_height),
    .row_stride   (row_stride),
    .accept       (accept),
    .bitmap_byte  (bitmap_byte),
    .push         (q_push),
    .push_data    (q_wdata)
  );

  mge_queue #(
    .EW    (EW),
    .DEPTH (mge_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  mge_back #(
    .COORD_BITS (COORD_BITS),
    .PIXEL_BITS (PIXEL_BITS),
    .EW         (EW)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .origin_x        (origin_x),
    .glyph_width     (glyph_width),
    .fg_color        (fg_color),
    .bg_color        (bg_color),
    .skip_background (skip_background),
    .head_valid      (!q_empty),
    .head            (q_head),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .op_kind         (op_kind),
    .win_left        (win_left),
    .win_right       (win_right),
    .win_row         (win_row),
    .pixel_word      (pixel_word),
    .last_of_item    (last_of_item),
    .glyph_done      (glyph_done)
  );

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && glyph_done |-> last_of_item)
    else $error("glyph_done without last_of_item");

  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("queue both full and empty");

  a_pixel_no_left: assert property (@(posedge clk) disable iff (rst)
    out_valid && op_kind == mge_pkg::OP_PIXEL |-> win_left == '0)
    else $error("pixel transfer carries a window column");

  a_pop_has_head: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule

// ----- design/mge_front.sv -----
// Front end: tracks row position, builds a queue entry for each accepted byte in the glyph that yields results.
module mge_front #(
  parameter int COORD_BITS = mge_pkg::COORD_BITS_DEF,
  parameter int EW         = 2 * COORD_BITS + 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  restart,
  input  logic [COORD_BITS-1:0] origin_x,
  input  logic [COORD_BITS-1:0] origin_y,
  input  logic [COORD_BITS-1:0] glyph_width,
  input  logic [COORD_BITS-1:0] glyph_height,
  input  logic [7:0]            row_stride,
  input  logic                  accept,
  input  logic [7:0]            bitmap_byte,
  output logic                  push,
  output logic [EW-1:0]         push_data
);

  localparam int DW = ((COORD_BITS > 11) ? COORD_BITS : 11) + 1;
  localparam logic [COORD_BITS-1:0] CMAX = '1;

  typedef struct packed {
    logic [7:0]            bits;
    logic                  hdr;
    logic [3:0]            nbits;
    logic [COORD_BITS-1:0] col_base;
    logic [COORD_BITS-1:0] row;
    logic                  done;
  } entry_t;

  logic [7:0]            byte_in_row;
  logic [COORD_BITS-1:0] rows_done;

  logic [DW-1:0]         bit_ofs, wid, rem, col_sum, wm1, done_at, done_lim;
  logic [COORD_BITS:0]   row_sum, rows_inc;
  logic [7:0]            stride;
  logic [8:0]            bir_inc;
  logic                  active, final_row, row_end;
  entry_t                ent;

  always_comb begin
    stride   = (row_stride == 8'd0) ? 8'd1 : row_stride;
    bit_ofs  = DW'({byte_in_row, 3'b000});
    wid      = DW'(glyph_width);
    rem      = wid - bit_ofs;
    col_sum  = DW'(origin_x) + bit_ofs;
    row_sum  = {1'b0, origin_y} + {1'b0, rows_done};
    rows_inc = {1'b0, rows_done} + 1'b1;
    active   = rows_done < glyph_height;
    final_row = rows_inc == {1'b0, glyph_height};
    wm1      = wid - 1'b1;
    done_at  = (glyph_width == '0) ? '0 : (wm1 >> 3);
    done_lim = DW'(stride - 8'd1);
    if (done_at > done_lim) begin
      done_at = done_lim;
    end
    bir_inc  = {1'b0, byte_in_row} + 9'd1;
    row_end  = bir_inc >= {1'b0, stride};

    ent.bits     = bitmap_byte;
    ent.hdr      = byte_in_row == 8'd0;
    if (wid > bit_ofs) begin
      ent.nbits = (rem > DW'(8)) ? 4'd8 : rem[3:0];
    end else begin
      ent.nbits = 4'd0;
    end
    ent.col_base = (col_sum > DW'(CMAX)) ? CMAX : col_sum[COORD_BITS-1:0];
    ent.row      = row_sum[COORD_BITS] ? CMAX : row_sum[COORD_BITS-1:0];
    ent.done     = final_row && (DW'(byte_in_row) == done_at);

    push      = accept && active && (ent.hdr || ent.nbits != 4'd0);
    push_data = ent;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      byte_in_row <= '0;
      rows_done   <= '0;
    end else if (accept && active) begin
      if (row_end) begin
        byte_in_row <= '0;
        rows_done   <= rows_inc[COORD_BITS-1:0];
      end else begin
        byte_in_row <= bir_inc[7:0];
      end
    end
  end

endmodule

// ----- design/mge_queue.sv -----
// Small register queue between front and back ends.
module mge_queue #(
  parameter int EW    = 36,
  parameter int DEPTH = mge_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [EW-1:0] push_data,
  input  logic          pop,
  output logic [EW-1:0] head,
  output logic          empty,
  output logic          full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [EW-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign empty = count == '0;
  assign full  = count == CW'(DEPTH);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- design/mge_back.sv -----
// Back end: expands one queue entry into window and pixel operations.
module mge_back #(
  parameter int COORD_BITS = mge_pkg::COORD_BITS_DEF,
  parameter int PIXEL_BITS = mge_pkg::PIXEL_BITS_DEF,
  parameter int EW         = 2 * COORD_BITS + 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [COORD_BITS-1:0] origin_x,
  input  logic [COORD_BITS-1:0] glyph_width,
  input  logic [PIXEL_BITS-1:0] fg_color,
  input  logic [PIXEL_BITS-1:0] bg_color,
  input  logic                  skip_background,
  input  logic                  head_valid,
  input  logic [EW-1:0]         head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  op_kind,
  output logic [COORD_BITS-1:0] win_left,
  output logic [COORD_BITS-1:0] win_right,
  output logic [COORD_BITS-1:0] win_row,
  output logic [PIXEL_BITS-1:0] pixel_word,
  output logic                  last_of_item,
  output logic                  glyph_done
);

  localparam logic [COORD_BITS-1:0] CMAX = '1;

  typedef struct packed {
    logic [7:0]            bits;
    logic                  hdr;
    logic [3:0]            nbits;
    logic [COORD_BITS-1:0] col_base;
    logic [COORD_BITS-1:0] row;
    logic                  done;
  } entry_t;

  entry_t                ent;
  logic [3:0]            step, total, t;
  logic [COORD_BITS:0]   col_sum, edge_sum;
  logic [COORD_BITS-1:0] col, right_edge;
  logic                  adv, fire, last, bitv;
  mge_pkg::op_kind_t     kind_next;
  logic [COORD_BITS-1:0] left_next;
  logic [PIXEL_BITS-1:0] pix_next;

  always_comb begin
    ent      = head;
    total    = 4'(ent.hdr) + ent.nbits;
    t        = step - 4'(ent.hdr);
    bitv     = ent.bits[3'd7 - t[2:0]];
    col_sum  = {1'b0, ent.col_base} + (COORD_BITS+1)'(t) + 1'b1;
    col      = col_sum[COORD_BITS] ? CMAX : col_sum[COORD_BITS-1:0];
    edge_sum = {1'b0, origin_x} + {1'b0, glyph_width};
    if (edge_sum == '0) begin
      right_edge = '0;
    end else begin
      edge_sum   = edge_sum - 1'b1;
      right_edge = edge_sum[COORD_BITS] ? CMAX : edge_sum[COORD_BITS-1:0];
    end
    last     = (step + 4'd1) == total;
    adv      = !out_valid || !out_stall;
    fire     = adv && head_valid;
    pop      = fire && last;

    if (ent.hdr && step == 4'd0) begin
      kind_next = mge_pkg::OP_WINDOW;
      left_next = ent.col_base;
      pix_next  = '0;
    end else if (bitv) begin
      kind_next = mge_pkg::OP_PIXEL;
      left_next = '0;
      pix_next  = fg_color;
    end else if (skip_background) begin
      kind_next = mge_pkg::OP_WINDOW;
      left_next = col;
      pix_next  = '0;
    end else begin
      kind_next = mge_pkg::OP_PIXEL;
      left_next = '0;
      pix_next  = bg_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        step      <= last ? 4'd0 : step + 4'd1;
      end else if (adv) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      op_kind      <= kind_next;
      win_left     <= left_next;
      win_right    <= right_edge;
      win_row      <= ent.row;
      pixel_word   <= pix_next;
      last_of_item <= last;
      glyph_done   <= last && ent.done;
    end
  end

endmodule
